/* rtl/se2rp_pkg.sv */
// shared types, constants and helpers for the se2 relative pose residual unit
`default_nettype none
package se2rp_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_REGS       = 6;
  localparam int TRIG_STEPS     = 7;

  localparam logic [2:0] REG_XX = 3'd0;
  localparam logic [2:0] REG_YX = 3'd1;
  localparam logic [2:0] REG_YY = 3'd2;
  localparam logic [2:0] REG_HX = 3'd3;
  localparam logic [2:0] REG_HY = 3'd4;
  localparam logic [2:0] REG_HH = 3'd5;

  localparam logic [30:0]        TRIG_ONE    = 31'h4000_0000;
  localparam logic signed [31:0] TRIG_ONE_S  = 32'sh4000_0000;
  localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0]        PI_Q30      = 32'd3373259426;

  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [15:0] first_heading;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [15:0] second_heading;
    logic signed [31:0] measured_dx;
    logic signed [31:0] measured_dy;
    logic signed [15:0] measured_dheading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] residual_x;
    logic signed [31:0] residual_y;
    logic signed [31:0] residual_heading;
    logic               saturated;
  } out_item_t;

  // payload carried down the series pipeline
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] eh;
    logic [1:0]         quad;
    logic [30:0]        x;
    logic [31:0]        x2;
    logic signed [31:0] ts;
    logic signed [31:0] tc;
    logic [31:0]        ms;
    logic [31:0]        mc;
    logic [63:0]        ps;
    logic [63:0]        pc;
  } trig_pipe_t;

  function automatic logic [30:0] clamp_unit(input logic signed [31:0] v);
    if (v < 0) return '0;
    if (v > TRIG_ONE_S) return TRIG_ONE;
    return v[30:0];
  endfunction

  // msb is the clip flag
  function automatic logic [32:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) return {1'b1, 32'h7fff_ffff};
    if (v < -67'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

endpackage
`default_nettype wire

/* rtl/se2_relative_pose_residual_unit.sv */
// top level: streaming se2 relative pose residual with sqrt-information weighting
`default_nettype none
// One item is taken in every clock cycle and its weighted residual appears on
// out_result with out_valid. Most of the pipeline is the cos/sin series: seven
// Horner steps, each a product, a reciprocal multiply and a correction in three
// register stages. busy stays low and there is no back-pressure; out_valid is a
// one-cycle strobe that the receiver must take. The user must write weights
// through the cfg port only while idle; the block does not enforce this.
module se2_relative_pose_residual_unit #(
  parameter int ANGLE_BITS = se2rp_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = se2rp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire se2rp_pkg::in_item_t in_item,
  output logic                     out_valid,
  output se2rp_pkg::out_item_t     out_result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  import se2rp_pkg::*;

  localparam int XPW      = ANGLE_BITS + 29;
  localparam int EPW      = ANGLE_BITS + 33;
  localparam int EH_SH    = ANGLE_BITS + 29 - FRAC_BITS;
  localparam int PIPE_LAT = 9 + 3 * TRIG_STEPS;
  localparam logic signed [EPW-1:0] EH_HALF = EPW'(1) << (EH_SH - 1);
  localparam logic signed [63:0]    W_HALF  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [64:0]    RND30   = 65'sd536870912;
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // weight registers
  logic signed [31:0] wgt_r [NUM_REGS];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wgt_r[REG_XX] <= 32'sd1 <<< FRAC_BITS;
      wgt_r[REG_YX] <= '0;
      wgt_r[REG_YY] <= 32'sd1 <<< FRAC_BITS;
      wgt_r[REG_HX] <= '0;
      wgt_r[REG_HY] <= '0;
      wgt_r[REG_HH] <= 32'sd1 <<< FRAC_BITS;
    end else if (cfg_valid && cfg_index < 3'(NUM_REGS)) begin
      wgt_r[cfg_index] <= cfg_data;
    end
  end

  // input register
  in_item_t in_r;
  logic     v0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= start;
    if (start) in_r <= in_item;
  end

  // stage 1: angle reduction, differences
  logic signed [ANGLE_BITS-1:0] ha_a, hb_a, mh_a;
  logic [XPW-1:0]               xprod;
  assign ha_a  = ANGLE_BITS'(in_r.first_heading);
  assign hb_a  = ANGLE_BITS'(in_r.second_heading);
  assign mh_a  = ANGLE_BITS'(in_r.measured_dheading);
  assign xprod = XPW'(ha_a[ANGLE_BITS-3:0]) * XPW'(HALF_PI_Q30);

  logic [30:0]                  s1_x_r;
  logic [1:0]                   s1_quad_r;
  logic signed [32:0]           s1_dx_r, s1_dy_r;
  logic signed [31:0]           s1_mx_r, s1_my_r;
  logic signed [ANGLE_BITS-1:0] s1_d_r;
  logic                         v1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v0_r;
    s1_x_r    <= xprod[XPW-1:ANGLE_BITS-2];
    s1_quad_r <= ha_a[ANGLE_BITS-1:ANGLE_BITS-2];
    s1_dx_r   <= 33'(in_r.second_pos_x) - 33'(in_r.first_pos_x);
    s1_dy_r   <= 33'(in_r.second_pos_y) - 33'(in_r.first_pos_y);
    s1_mx_r   <= in_r.measured_dx;
    s1_my_r   <= in_r.measured_dy;
    s1_d_r    <= hb_a - ha_a - mh_a;
  end

  // stage 2: x squared, heading error times pi
  logic [61:0]  x2p;
  trig_pipe_t   s2_nxt, s2_r;
  logic signed [EPW-1:0] s2_ehp_r;
  logic         v2_r;
  assign x2p = 62'(s1_x_r) * 62'(s1_x_r);
  always_comb begin
    s2_nxt      = '0;
    s2_nxt.dx   = s1_dx_r;
    s2_nxt.dy   = s1_dy_r;
    s2_nxt.mx   = s1_mx_r;
    s2_nxt.my   = s1_my_r;
    s2_nxt.quad = s1_quad_r;
    s2_nxt.x    = s1_x_r;
    s2_nxt.x2   = x2p[61:30];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    s2_r      <= s2_nxt;
    s2_ehp_r  <= EPW'(s1_d_r) * EPW'(signed'({1'b0, PI_Q30}));
  end

  trig_pipe_t ent;
  always_comb begin
    ent    = s2_r;
    ent.eh = 32'((s2_ehp_r + EH_HALF) >>> EH_SH);
    ent.ts = TRIG_ONE_S;
    ent.tc = TRIG_ONE_S;
  end

  // horner steps of the sin and cos series
  trig_pipe_t sa_r [TRIG_STEPS];
  trig_pipe_t sb_r [TRIG_STEPS];
  trig_pipe_t sc_r [TRIG_STEPS];
  logic [TRIG_STEPS-1:0] va_r, vb_r, vc_r;

  for (genvar j = 0; j < TRIG_STEPS; j++) begin : g_step
    localparam int CK   = 14 - 2 * j;
    localparam int SK   = 15 - 2 * j;
    localparam int CDIV = CK * (CK - 1);
    localparam int SDIV = SK * (SK - 1);
    localparam logic [31:0] CMAG = 32'((64'd1 << 32) / CDIV);
    localparam logic [31:0] SMAG = 32'((64'd1 << 32) / SDIV);
    localparam bit SIN_ON = (j > 0);

    trig_pipe_t st_in, a_nxt, b_nxt, c_nxt;
    logic       st_v;
    logic [62:0] mcp, msp;
    logic [31:0] qc0, qs0, remc, rems, qc, qs;

    if (j == 0) begin : g_first
      assign st_in = ent;
      assign st_v  = v2_r;
    end else begin : g_next
      assign st_in = sc_r[j-1];
      assign st_v  = vc_r[j-1];
    end

    assign mcp = 63'(st_in.x2) * 63'(clamp_unit(st_in.tc));
    assign msp = 63'(st_in.x2) * 63'(clamp_unit(st_in.ts));
    always_comb begin
      a_nxt    = st_in;
      a_nxt.mc = mcp[61:30];
      a_nxt.ms = msp[61:30];
    end

    always_comb begin
      b_nxt    = sa_r[j];
      b_nxt.pc = 64'(sa_r[j].mc) * 64'(CMAG);
      b_nxt.ps = 64'(sa_r[j].ms) * 64'(SMAG);
    end

    // quotient estimate is low by at most one
    assign qc0  = sb_r[j].pc[63:32];
    assign qs0  = sb_r[j].ps[63:32];
    assign remc = sb_r[j].mc - 32'(qc0 * 32'(CDIV));
    assign rems = sb_r[j].ms - 32'(qs0 * 32'(SDIV));
    assign qc   = qc0 + 32'(remc >= 32'(CDIV));
    assign qs   = qs0 + 32'(rems >= 32'(SDIV));
    always_comb begin
      c_nxt    = sb_r[j];
      c_nxt.tc = TRIG_ONE_S - signed'(qc);
      if (SIN_ON) c_nxt.ts = TRIG_ONE_S - signed'(qs);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[j] <= 1'b0;
        vb_r[j] <= 1'b0;
        vc_r[j] <= 1'b0;
      end else begin
        va_r[j] <= st_v;
        vb_r[j] <= va_r[j];
        vc_r[j] <= vb_r[j];
      end
      sa_r[j] <= a_nxt;
      sb_r[j] <= b_nxt;
      sc_r[j] <= c_nxt;
    end
  end

  // final sin product and clamp
  trig_pipe_t  tr_last;
  logic [61:0] sp;
  assign tr_last = sc_r[TRIG_STEPS-1];
  assign sp      = 62'(tr_last.x) * 62'(clamp_unit(tr_last.ts));

  trig_pipe_t  f1_r, f2_r, r1_r;
  logic [30:0] f1_s0_r, f1_c0_r;
  logic        vf1_r, vf2_r, vr1_r, vr2_r, vw1_r, out_valid_r;
  always_ff @(posedge clk) begin
    f1_r    <= tr_last;
    f1_s0_r <= clamp_unit(signed'(sp[61:30]));
    f1_c0_r <= clamp_unit(tr_last.tc);
  end

  // quadrant mapping
  logic signed [31:0] c0s, s0s, cs_nxt, sn_nxt, f2_cs_r, f2_sn_r;
  assign c0s = signed'(32'(f1_c0_r));
  assign s0s = signed'(32'(f1_s0_r));
  always_comb begin
    case (f1_r.quad)
      QUAD_0: begin cs_nxt = c0s;  sn_nxt = s0s;  end
      QUAD_1: begin cs_nxt = -s0s; sn_nxt = c0s;  end
      QUAD_2: begin cs_nxt = -c0s; sn_nxt = -s0s; end
      default: begin cs_nxt = s0s; sn_nxt = -c0s; end
    endcase
  end
  always_ff @(posedge clk) begin
    f2_r    <= f1_r;
    f2_cs_r <= cs_nxt;
    f2_sn_r <= sn_nxt;
  end

  // rotation products
  logic signed [64:0] pcx_r, psy_r, pcy_r, psx_r;
  always_ff @(posedge clk) begin
    r1_r  <= f2_r;
    pcx_r <= 65'(f2_cs_r) * 65'(f2_r.dx);
    psy_r <= 65'(f2_sn_r) * 65'(f2_r.dy);
    pcy_r <= 65'(f2_cs_r) * 65'(f2_r.dy);
    psx_r <= 65'(f2_sn_r) * 65'(f2_r.dx);
  end

  // rounding, measured offset, clip
  logic signed [64:0] rcx, rsy, rcy, rsx;
  logic signed [66:0] ex_w, ey_w;
  logic [32:0]        ex_s, ey_s;
  assign rcx  = (pcx_r + RND30) >>> 30;
  assign rsy  = (psy_r + RND30) >>> 30;
  assign rcy  = (pcy_r + RND30) >>> 30;
  assign rsx  = (psx_r + RND30) >>> 30;
  assign ex_w = 67'(rcx) + 67'(rsy) - 67'(r1_r.mx);
  assign ey_w = 67'(rcy) - 67'(rsx) - 67'(r1_r.my);
  assign ex_s = sat32(ex_w);
  assign ey_s = sat32(ey_w);

  logic signed [31:0] ex_r, ey_r, eh_r;
  logic               r2_clip_r;
  always_ff @(posedge clk) begin
    ex_r      <= signed'(ex_s[31:0]);
    ey_r      <= signed'(ey_s[31:0]);
    eh_r      <= r1_r.eh;
    r2_clip_r <= ex_s[32] | ey_s[32];
  end

  // weight products
  logic signed [63:0] pxx_r, pyx_r, pyy_r, phx_r, phy_r, phh_r;
  logic               w1_clip_r;
  always_ff @(posedge clk) begin
    pxx_r     <= 64'(wgt_r[REG_XX]) * 64'(ex_r);
    pyx_r     <= 64'(wgt_r[REG_YX]) * 64'(ex_r);
    pyy_r     <= 64'(wgt_r[REG_YY]) * 64'(ey_r);
    phx_r     <= 64'(wgt_r[REG_HX]) * 64'(ex_r);
    phy_r     <= 64'(wgt_r[REG_HY]) * 64'(ey_r);
    phh_r     <= 64'(wgt_r[REG_HH]) * 64'(eh_r);
    w1_clip_r <= r2_clip_r;
  end

  // row sums and output clip
  logic signed [63:0] rxx, ryx, ryy, rhx, rhy, rhh;
  logic [32:0]        r0_s, r1_s, r2_s;
  assign rxx  = (pxx_r + W_HALF) >>> FRAC_BITS;
  assign ryx  = (pyx_r + W_HALF) >>> FRAC_BITS;
  assign ryy  = (pyy_r + W_HALF) >>> FRAC_BITS;
  assign rhx  = (phx_r + W_HALF) >>> FRAC_BITS;
  assign rhy  = (phy_r + W_HALF) >>> FRAC_BITS;
  assign rhh  = (phh_r + W_HALF) >>> FRAC_BITS;
  assign r0_s = sat32(67'(rxx));
  assign r1_s = sat32(67'(ryx) + 67'(ryy));
  assign r2_s = sat32(67'(rhx) + 67'(rhy) + 67'(rhh));

  out_item_t out_res_r;
  always_ff @(posedge clk) begin
    out_res_r.residual_x       <= signed'(r0_s[31:0]);
    out_res_r.residual_y       <= signed'(r1_s[31:0]);
    out_res_r.residual_heading <= signed'(r2_s[31:0]);
    out_res_r.saturated        <= w1_clip_r | r0_s[32] | r1_s[32] | r2_s[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf1_r       <= 1'b0;
      vf2_r       <= 1'b0;
      vr1_r       <= 1'b0;
      vr2_r       <= 1'b0;
      vw1_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vf1_r       <= vc_r[TRIG_STEPS-1];
      vf2_r       <= vf1_r;
      vr1_r       <= vf2_r;
      vr2_r       <= vr1_r;
      vw1_r       <= vr2_r;
      out_valid_r <= vw1_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

  // every result traces back to an earlier accepted item
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE_LAT))
    else $error("result without matching item");

  // cos and sin stay within the unit range after quadrant mapping
  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    vf2_r |-> (f2_cs_r <= TRIG_ONE_S) && (f2_cs_r >= -TRIG_ONE_S) &&
              (f2_sn_r <= TRIG_ONE_S) && (f2_sn_r >= -TRIG_ONE_S))
    else $error("cos or sin out of range");

endmodule
`default_nettype wire

/* test/tb_se2_relative_pose_residual_unit.sv */
// testbench for the se2 relative pose residual unit: directed and random poses against a built-in predictor
`default_nettype none
module tb_se2_relative_pose_residual_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import se2rp_pkg::*;

  class residual_scoreboard;
    logic [31:0] weight [NUM_REGS];
    out_item_t   awaited [$];
    int          errors;

    function new();
      weight[REG_XX] = 32'h0001_0000;
      weight[REG_YX] = '0;
      weight[REG_YY] = 32'h0001_0000;
      weight[REG_HX] = '0;
      weight[REG_HY] = '0;
      weight[REG_HH] = 32'h0001_0000;
      errors = 0;
    endfunction

    function void set_weight(logic [2:0] idx, logic [31:0] val);
      if (idx < NUM_REGS) weight[idx] = val;
    endfunction

    function longint unit(longint v);
      if (v < 0) return 0;
      if (v > 64'sd1073741824) return 64'sd1073741824;
      return v;
    endfunction

    function longint rnd(longint v, int s);
      return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function longint clip(longint v, ref bit hit);
      if (v > 64'sd2147483647) begin
        hit = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        hit = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint wmul(logic [31:0] w, longint e);
      longint ws;
      ws = longint'($signed(w));
      return rnd(ws * e, FRAC_BITS_DEF);
    endfunction

    // predict one item and queue the residual it should produce
    function void note_edge(in_item_t it);
      logic [15:0] a, hd;
      longint r, x, x2, t, m, s0, c0, cs, sn, dx, dy, ex, ey, eh, d;
      longint one;
      bit hit;
      out_item_t res;
      one = 64'sd1073741824;
      hit = 0;
      a = it.first_heading;
      r = longint'(a[13:0]);
      x = (r * 64'sd1686629713) >>> 14;
      x2 = (x * x) >>> 30;
      t = one;
      for (int k = 13; k >= 3; k -= 2) t = one - ((x2 * t) >>> 30) / (k * (k - 1));
      s0 = unit((x * t) >>> 30);
      t = one;
      for (int k = 14; k >= 2; k -= 2) begin
        m = (x2 * unit(t)) >>> 30;
        t = one - m / (k * (k - 1));
      end
      c0 = unit(t);
      case (a[15:14])
        2'd0: begin cs = c0;  sn = s0;  end
        2'd1: begin cs = -s0; sn = c0;  end
        2'd2: begin cs = -c0; sn = -s0; end
        default: begin cs = s0; sn = -c0; end
      endcase
      dx = longint'(it.second_pos_x) - longint'(it.first_pos_x);
      dy = longint'(it.second_pos_y) - longint'(it.first_pos_y);
      ex = rnd(cs * dx, 30) + rnd(sn * dy, 30) - longint'(it.measured_dx);
      ey = rnd(cs * dy, 30) - rnd(sn * dx, 30) - longint'(it.measured_dy);
      ex = clip(ex, hit);
      ey = clip(ey, hit);
      hd = it.second_heading - it.first_heading - it.measured_dheading;
      d = longint'($signed(hd));
      eh = rnd(d * 64'sd3373259426, 29);
      res.residual_x = 32'(clip(wmul(weight[REG_XX], ex), hit));
      res.residual_y = 32'(clip(wmul(weight[REG_YX], ex) + wmul(weight[REG_YY], ey), hit));
      res.residual_heading = 32'(clip(wmul(weight[REG_HX], ex) + wmul(weight[REG_HY], ey)
                                      + wmul(weight[REG_HH], eh), hit));
      res.saturated = hit;
      awaited.insert(awaited.size(), res);
    endfunction

    function void check_residual(out_item_t got);
      out_item_t exp_r;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected residual %h", $time, got);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      if (got.residual_x !== exp_r.residual_x) begin
        $display("%0t: residual_x expected %h actual %h", $time, exp_r.residual_x, got.residual_x);
        errors++;
      end
      if (got.residual_y !== exp_r.residual_y) begin
        $display("%0t: residual_y expected %h actual %h", $time, exp_r.residual_y, got.residual_y);
        errors++;
      end
      if (got.residual_heading !== exp_r.residual_heading) begin
        $display("%0t: residual_heading expected %h actual %h", $time,
                 exp_r.residual_heading, got.residual_heading);
        errors++;
      end
      if (got.saturated !== exp_r.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time, exp_r.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  residual_scoreboard sb;
  bit burst;

  se2_relative_pose_residual_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_result(out_result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_edge(in_item);
      if (out_valid) sb.check_residual(out_result);
    end
  end

  task automatic write_weight(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_weight(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // start stays high across back-to-back items
  task automatic send_pose(in_item_t it);
    int gap;
    @(negedge clk);
    start <= 1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk);
      start <= 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_q(int near);
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return 32'(near + $signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic in_item_t random_pose();
    in_item_t it;
    it.first_pos_x = pick_q(0);
    it.first_pos_y = pick_q(0);
    it.second_pos_x = pick_q(int'(it.first_pos_x));
    it.second_pos_y = pick_q(int'(it.first_pos_y));
    it.measured_dx = pick_q(0);
    it.measured_dy = pick_q(0);
    it.first_heading = 16'($urandom());
    it.second_heading = 16'($urandom());
    it.measured_dheading = 16'($urandom());
    return it;
  endfunction

  task automatic weight_set(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                            logic [31:0] v3, logic [31:0] v4, logic [31:0] v5);
    write_weight(REG_XX, v0);
    write_weight(REG_YX, v1);
    write_weight(REG_YY, v2);
    write_weight(REG_HX, v3);
    write_weight(REG_HY, v4);
    write_weight(REG_HH, v5);
  endtask

  initial begin
    in_item_t it;
    int hd [6];
    sb = new();
    rst_n = 0;
    start = 0;
    in_item = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    burst = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: headings at quadrant edges, half-turn wrap, large errors
    hd = '{0, 16384, -32768, -1, 32767, -16384};
    foreach (hd[i]) begin
      it = '0;
      it.first_heading = 16'(hd[i]);
      it.second_pos_x = 32'h0003_0000;
      it.second_pos_y = 32'hfffe_8000;
      it.second_heading = 16'(hd[5 - i]);
      it.measured_dheading = 16'(hd[(i + 2) % 6]);
      send_pose(it);
    end
    it = '0;
    it.second_heading = 16'h8000;
    send_pose(it);
    it = '0;
    it.first_pos_x = 32'h8000_0000;
    it.second_pos_x = 32'h7fff_ffff;
    it.first_pos_y = 32'h7fff_ffff;
    it.second_pos_y = 32'h8000_0000;
    it.measured_dx = 32'h8000_0000;
    it.measured_dy = 32'h7fff_ffff;
    send_pose(it);
    it = '1;
    send_pose(it);
    it = {32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff, 32'h8000_0000, 32'h8000_0000,
          16'h8000, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff};
    send_pose(it);
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: weight_set(32'h0001_0000, 32'h0000_4000, 32'h0002_0000,
                      32'hffff_0000, 32'h0000_8000, 32'h0000_c000);
        1: weight_set(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        2: weight_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        3: weight_set(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        default: weight_set($urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom());
      endcase
      // out-of-range indexes must leave the weights alone
      write_weight(3'd6, $urandom());
      write_weight(3'd7, $urandom());
      for (int n = 0; n < 100; n++) begin
        if (n % 25 == 0) burst = 1'($urandom_range(0, 1));
        send_pose(random_pose());
      end
      settle();
    end

    if (sb.errors == 0 && sb.awaited.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
